[rtl/bra_pkg.sv]
// bra_pkg: shared types, codes and the byte scan function of the bitmap run allocator
// depends on nothing; imported by bitmap_run_allocator_unit and the testbench
package bra_pkg;

  localparam int UNIT_W = 12;
  localparam int LEN_W  = 13;
  localparam int CFG_W  = 10;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TEST  = 2'd1,
    OP_SCAN  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_BIT,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [LEN_W-1:0]  run;
    logic [UNIT_W-1:0] start;
  } scan_res_t;

  // walks the eight units of one map byte, lowest bit first
  function automatic scan_res_t scan_byte(input logic [7:0]        data,
                                          input logic [LEN_W-1:0]  run_in,
                                          input logic [LEN_W-1:0]  len,
                                          input logic [8:0]        byte_pos);
    scan_res_t        r;
    logic [LEN_W-1:0] run;
    logic [LEN_W-1:0] unit;
    r    = '0;
    run  = run_in;
    unit = '0;
    for (int b = 0; b < 8; b++) begin
      if (!r.hit) begin
        run = data[b] ? '0 : run + LEN_W'(1);
        if (run == len) begin
          r.hit   = 1'b1;
          unit    = {1'b0, byte_pos, 3'(b)};
          r.start = UNIT_W'(unit + LEN_W'(1) - len);
        end
      end
    end
    r.run = run;
    return r;
  endfunction

endpackage

[rtl/bra_map_ram.sv]
// bra_map_ram: byte-wide usage map storage, one write and one read port
// read data registered, valid in the cycle after the read; no reset, cleared by a sweep from the top level
module bra_map_ram #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/bitmap_run_allocator_unit.sv]
// bitmap_run_allocator_unit: first-fit free run allocator over a byte-wide usage bitmap
// depends on bra_pkg and bra_map_ram
//
//   channel  handshake              payload
//   req      req_valid/req_ready    operation, bit_index, run_length, set_value
//   rsp      rsp_valid/rsp_ready    found, start_index, bit_value
//   cfg      cfg_valid/cfg_ready    bytes_in_use
//
// test and write pass from request to result through read, modify/write and result states
// a scan reads one map byte per cycle and ends early on a hit
// a clear sweeps every map byte
// after reset a clearing sweep of every map byte runs with req_ready low; cfg is always ready
// a finished result waits in the output register; the next request is taken meanwhile
module bitmap_run_allocator_unit #(
  parameter int MAX_BYTES = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [1:0]                operation,
  input  logic [bra_pkg::UNIT_W-1:0] bit_index,
  input  logic [bra_pkg::LEN_W-1:0] run_length,
  input  logic                      set_value,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic                      found,
  output logic [bra_pkg::UNIT_W-1:0] start_index,
  output logic                      bit_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bra_pkg::CFG_W-1:0] bytes_in_use
);

  import bra_pkg::*;

  localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [CFG_W-1:0]  MB_CAP   = CFG_W'((MAX_BYTES < 512) ? MAX_BYTES : 512);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_BYTES - 1);

  state_t state, state_next;

  logic [CFG_W-1:0]  cfg_bytes;
  logic [CFG_W-1:0]  mb;
  logic [LEN_W-1:0]  units;

  logic [ADDR_W-1:0] clr_addr;
  logic              clr_reply;

  op_t               op_q;
  logic [UNIT_W-1:0] idx_q;
  logic [LEN_W-1:0]  len_q;
  logic              val_q;
  logic              in_range_q;

  logic [CFG_W-1:0]  scan_addr;
  logic              scan_pend;
  logic [8:0]        byte_pos;
  logic [LEN_W-1:0]  run_cnt;
  logic              issue_ok;
  scan_res_t         scan_r;

  logic              res_found;
  logic [UNIT_W-1:0] res_start;
  logic              res_bit;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        bit_mask;
  logic              out_free;

  bra_map_ram #(
    .DEPTH  (MAX_BYTES),
    .ADDR_W (ADDR_W)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // managed range, capped by store size and the 12-bit unit reach
  assign mb        = (cfg_bytes > MB_CAP) ? MB_CAP : cfg_bytes;
  assign units     = {mb, 3'b000};
  assign issue_ok  = scan_addr < mb;
  assign scan_r    = scan_byte(rd_data, run_cnt, len_q, byte_pos);
  assign bit_mask  = 8'h01 << idx_q[2:0];
  assign out_free  = !rsp_valid || rsp_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == CLR_LAST) begin
          state_next = clr_reply ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          case (op_t'(operation))
            OP_CLEAR: state_next = ST_CLEAR;
            OP_SCAN:  state_next = ST_SCAN;
            default:  state_next = ST_FETCH;
          endcase
        end
      end
      ST_FETCH: state_next = ST_BIT;
      ST_BIT:   state_next = ST_RESULT;
      ST_SCAN: begin
        if ((scan_pend && scan_r.hit) || (!scan_pend && !issue_ok)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = ADDR_W'(idx_q[UNIT_W-1:3]);
    wr_data   = val_q ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
    rd_en     = 1'b0;
    rd_addr   = ADDR_W'(idx_q[UNIT_W-1:3]);
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = 8'h00;
      end
      ST_IDLE:  req_ready = 1'b1;
      ST_FETCH: rd_en = in_range_q;
      ST_BIT:   wr_en = in_range_q && (op_q == OP_WRITE);
      ST_SCAN: begin
        rd_en   = issue_ok;
        rd_addr = ADDR_W'(scan_addr);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cfg_bytes <= CFG_W'(512);
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      scan_pend <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        cfg_bytes <= bytes_in_use;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_IDLE && req_valid) begin
        clr_addr  <= '0;
        clr_reply <= 1'b1;
        scan_pend <= 1'b0;
      end
      if (state == ST_SCAN) begin
        scan_pend <= issue_ok;
      end
      if (state == ST_RESULT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request fields, scan progress and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op_q       <= op_t'(operation);
          idx_q      <= bit_index;
          len_q      <= (run_length == '0) ? LEN_W'(1) : run_length;
          val_q      <= set_value;
          in_range_q <= {1'b0, bit_index} < units;
          scan_addr  <= '0;
          byte_pos   <= '0;
          run_cnt    <= '0;
          res_found  <= 1'b0;
          res_start  <= '0;
          res_bit    <= 1'b0;
        end
      end
      ST_BIT: begin
        res_bit <= in_range_q && (op_q == OP_TEST) && rd_data[idx_q[2:0]];
      end
      ST_SCAN: begin
        if (issue_ok) begin
          scan_addr <= scan_addr + CFG_W'(1);
          byte_pos  <= scan_addr[8:0];
        end
        if (scan_pend) begin
          run_cnt <= scan_r.run;
          if (scan_r.hit) begin
            res_found <= 1'b1;
            res_start <= scan_r.start;
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          found       <= res_found;
          start_index <= res_start;
          bit_value   <= res_bit;
        end
      end
      default: begin
      end
    endcase
  end

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found |-> ({1'b0, start_index} < units))
    else $error("found run starts outside managed range");

  a_no_stale_start: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> (start_index == '0))
    else $error("start_index nonzero without a found run");

  a_one_meaning: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(found && bit_value))
    else $error("scan and test fields both set");

  a_scan_read_only: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !wr_en)
    else $error("map written during a scan");

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_RESULT)
    else $error("response raised outside result state");

endmodule

[tb/tb_bitmap_run_allocator_unit.sv]
// tb_bitmap_run_allocator_unit: self-checking bench for the bitmap run allocator
// keeps its own copy of the usage map to predict every response; needs bra_pkg and the rtl
module tb_bitmap_run_allocator_unit;
  import bra_pkg::*;

  localparam int MAP_BYTES = 512;
  localparam int PHASES = 12;
  localparam logic [CFG_W-1:0] PHASE_BYTES [PHASES] =
    '{10'd512, 10'd1, 10'd0, 10'd3, 10'd16, 10'd64, 10'd1023, 10'd200, 10'd511, 10'd37,
      10'd600, 10'd512};
  localparam int PHASE_ITEMS [PHASES] =
    '{200, 60, 30, 80, 120, 120, 120, 100, 100, 80, 60, 80};

  typedef struct packed {
    logic              found;
    logic [UNIT_W-1:0] start;
    logic              bit_val;
  } answer_t;

  class alloc_scoreboard #(int BYTES = 512);
    logic [7:0]       unit_map [BYTES];
    logic [CFG_W-1:0] map_bytes;
    answer_t          pending_answers [$];
    int               errors;
    int               answers_seen;
    int               requests;
    int               scans;
    int               hits;

    function new();
      foreach (unit_map[k]) unit_map[k] = 8'h00;
      map_bytes    = CFG_W'(512);
      errors       = 0;
      answers_seen = 0;
      requests     = 0;
      scans        = 0;
      hits         = 0;
    endfunction

    function int unsigned unit_count();
      int unsigned b;
      int unsigned u;
      b = map_bytes;
      if (b > BYTES) b = BYTES;
      u = b * 8;
      return (u > 4096) ? 4096 : u;
    endfunction

    // applies one accepted request to the map and queues the response it must give
    function answer_t note_request(op_t op, logic [UNIT_W-1:0] idx, logic [LEN_W-1:0] len,
                                   logic val);
      answer_t     a;
      int unsigned units;
      int unsigned run;
      int unsigned want;
      a     = '0;
      units = unit_count();
      requests++;
      case (op)
        OP_CLEAR: begin
          foreach (unit_map[k]) unit_map[k] = 8'h00;
        end
        OP_TEST: begin
          if (idx < units) a.bit_val = unit_map[idx / 8][idx % 8];
        end
        OP_WRITE: begin
          if (idx < units) unit_map[idx / 8][idx % 8] = val;
        end
        OP_SCAN: begin
          scans++;
          want = (len == 0) ? 1 : len;
          run  = 0;
          for (int unsigned u = 0; u < units; u++) begin
            run = unit_map[u / 8][u % 8] ? 0 : run + 1;
            if (run == want) begin
              a.found = 1'b1;
              a.start = UNIT_W'(u + 1 - want);
              hits++;
              break;
            end
          end
        end
      endcase
      pending_answers.push_back(a);
      return a;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_response(logic f, logic [UNIT_W-1:0] s, logic b);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report($sformatf("response with nothing pending: found=%0d start=%0d bit=%0d",
                         f, s, b));
      end else begin
        want = pending_answers.pop_front();
        answers_seen++;
        if (f !== want.found)
          report($sformatf("found %0d, want %0d", f, want.found));
        if (s !== want.start)
          report($sformatf("start_index %0d, want %0d", s, want.start));
        if (b !== want.bit_val)
          report($sformatf("bit_value %0d, want %0d", b, want.bit_val));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  logic [1:0]        operation;
  logic [UNIT_W-1:0] bit_index;
  logic [LEN_W-1:0]  run_length;
  logic              set_value;
  logic              rsp_valid;
  logic              rsp_ready;
  logic              found;
  logic [UNIT_W-1:0] start_index;
  logic              bit_value;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  bytes_in_use;

  alloc_scoreboard #(MAP_BYTES) sb;
  bit req_burst;
  bit rsp_burst;
  int configs = 0;

  bitmap_run_allocator_unit #(
    .MAX_BYTES(MAP_BYTES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .operation   (operation),
    .bit_index   (bit_index),
    .run_length  (run_length),
    .set_value   (set_value),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .found       (found),
    .start_index (start_index),
    .bit_value   (bit_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .bytes_in_use(bytes_in_use)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  // mostly inside the managed range, sometimes anywhere in the 12-bit space
  function automatic logic [UNIT_W-1:0] pick_index(int unsigned units);
    if (units == 0 || $urandom_range(0, 4) == 0) return UNIT_W'($urandom_range(0, 4095));
    return UNIT_W'($urandom_range(0, units - 1));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(op_t op, logic [UNIT_W-1:0] idx, logic [LEN_W-1:0] len, logic val,
                          output answer_t predicted);
    int gap;
    gap = draw_gap(req_burst);
    if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation  <= op;
    bit_index  <= idx;
    run_length <= len;
    set_value  <= val;
    req_valid  <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = sb.note_request(op, idx, len, val);
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic write_bytes_in_use(logic [CFG_W-1:0] v);
    cfg_valid    <= 1'b1;
    bytes_in_use <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.map_bytes = v;
    configs++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int budget);
    answer_t           got;
    answer_t           spare;
    int unsigned       units;
    int                done;
    int                pick;
    int                span;
    logic [UNIT_W-1:0] first;
    done  = 0;
    units = sb.unit_count();
    while (done < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // allocation: find a run, mark it used, spot-check one of its units
        span = $urandom_range(1, 12);
        send_req(OP_SCAN, UNIT_W'($urandom), LEN_W'(span), 1'($urandom), got);
        done++;
        if (got.found) begin
          first = got.start;
          for (int k = 0; k < span; k++)
            send_req(OP_WRITE, first + UNIT_W'(k), LEN_W'($urandom), 1'b1, spare);
          send_req(OP_TEST, first + UNIT_W'($urandom_range(0, span - 1)), LEN_W'($urandom),
                   1'($urandom), spare);
          done += span + 1;
        end
      end else if (pick < 65) begin
        // release a short stretch
        first = pick_index(units);
        span  = $urandom_range(1, 8);
        for (int k = 0; k < span; k++)
          send_req(OP_WRITE, first + UNIT_W'(k), LEN_W'($urandom), 1'b0, spare);
        done += span;
      end else if (pick < 80) begin
        send_req(OP_TEST, pick_index(units), LEN_W'($urandom), 1'($urandom), spare);
        done++;
      end else if (pick < 90) begin
        if ($urandom_range(0, 1) == 0)
          send_req(OP_SCAN, UNIT_W'($urandom), LEN_W'($urandom_range(0, 8191)), 1'($urandom),
                   spare);
        else
          send_req(OP_SCAN, UNIT_W'($urandom), LEN_W'($urandom_range(0, units + 8)),
                   1'($urandom), spare);
        done++;
      end else if (pick < 97) begin
        send_req(OP_WRITE, UNIT_W'($urandom_range(0, 4095)), LEN_W'($urandom), 1'($urandom),
                 spare);
        done++;
      end else if (pick < 99) begin
        send_req(OP_CLEAR, UNIT_W'($urandom), LEN_W'($urandom), 1'($urandom), spare);
        done++;
      end else begin
        send_req(OP_SCAN, UNIT_W'($urandom), '0, 1'($urandom), spare);
        done++;
      end
    end
  endtask

  initial begin : response_side
    int gap;
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap(rsp_burst);
      if ($urandom_range(0, 29) == 0) rsp_burst = !rsp_burst;
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      sb.check_response(found, start_index, bit_value);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    answer_t got;
    sb           = new();
    rst          = 1'b1;
    req_valid    = 1'b0;
    operation    = OP_CLEAR;
    bit_index    = '0;
    run_length   = '0;
    set_value    = 1'b0;
    cfg_valid    = 1'b0;
    bytes_in_use = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full map: longest runs, zero length, high start index
    write_bytes_in_use(10'd512);
    send_req(OP_SCAN, 12'd0, 13'd4096, 1'b0, got);
    send_req(OP_SCAN, 12'd0, 13'd4097, 1'b0, got);
    send_req(OP_SCAN, 12'd0, 13'd0, 1'b0, got);
    send_req(OP_WRITE, 12'd4095, 13'd0, 1'b1, got);
    send_req(OP_TEST, 12'd4095, 13'd0, 1'b0, got);
    send_req(OP_WRITE, 12'd4095, 13'd0, 1'b0, got);
    send_req(OP_WRITE, 12'd2047, 13'd0, 1'b1, got);
    send_req(OP_SCAN, 12'd0, 13'd2048, 1'b0, got);
    send_req(OP_SCAN, 12'hfff, 13'h1fff, 1'b1, got);
    send_req(OP_TEST, 12'd2047, 13'd0, 1'b0, got);
    send_req(OP_WRITE, 12'd100, 13'd0, 1'b1, got);
    drain();

    // one byte: accesses past the range, exact fit, then clear beyond the range
    write_bytes_in_use(10'd1);
    send_req(OP_WRITE, 12'd8, 13'd0, 1'b1, got);
    send_req(OP_TEST, 12'd8, 13'd0, 1'b0, got);
    send_req(OP_WRITE, 12'd3, 13'd0, 1'b1, got);
    send_req(OP_SCAN, 12'd0, 13'd4, 1'b0, got);
    send_req(OP_SCAN, 12'd0, 13'd5, 1'b0, got);
    send_req(OP_CLEAR, 12'd0, 13'd0, 1'b0, got);
    drain();

    // no managed bytes at all
    write_bytes_in_use(10'd0);
    send_req(OP_SCAN, 12'd0, 13'd1, 1'b0, got);
    send_req(OP_WRITE, 12'd0, 13'd0, 1'b1, got);
    send_req(OP_TEST, 12'd0, 13'd0, 1'b0, got);
    drain();

    // oversized setting is capped at the full map
    write_bytes_in_use(10'd1023);
    send_req(OP_TEST, 12'd100, 13'd0, 1'b0, got);
    send_req(OP_TEST, 12'd0, 13'd0, 1'b0, got);
    send_req(OP_SCAN, 12'd0, 13'd4096, 1'b0, got);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_bytes_in_use(PHASE_BYTES[p]);
      run_random(PHASE_ITEMS[p]);
    end
    drain();
    repeat (40) @(posedge clk);

    $display("ran %0d requests over %0d map size settings; %0d scans, %0d found a run",
             sb.requests, configs, sb.scans, sb.hits);
    $display("%0d responses checked, %0d mismatches", sb.answers_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_bitmap_run_allocator_unit passed");
    end else begin
      $display("tb_bitmap_run_allocator_unit failed");
    end
    $finish;
  end

  initial begin : watchdog
    #30000000;
    $display("timeout with %0d responses outstanding", sb.pending_answers.size());
    $display("tb_bitmap_run_allocator_unit failed");
    $finish;
  end

endmodule
